@@ sv/class_phase_time_slice_sequencer_assert.svh @@
// assertion macros used by the cpts_checker file
`ifndef CLASS_PHASE_TIME_SLICE_SEQUENCER_ASSERT_SVH
`define CLASS_PHASE_TIME_SLICE_SEQUENCER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define CPTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpts assertion failed");

// next-cycle implication, off while reset is high
`define CPTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpts assertion failed");

`endif

@@ sv/cpts_pkg.sv @@
package cpts_pkg;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLICE_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PREEMPT_QUOTA = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RR_ROUNDS     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SJF_ROUNDS    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FCFS_ROUNDS   = 3'd4;

   // register reset values
   localparam logic [7:0] SLICE_LENGTH_RESET  = 8'd10;
   localparam logic [7:0] PREEMPT_QUOTA_RESET = 8'd5;
   localparam logic [3:0] RR_ROUNDS_RESET     = 4'd3;
   localparam logic [3:0] SJF_ROUNDS_RESET    = 4'd2;
   localparam logic [3:0] FCFS_ROUNDS_RESET   = 4'd1;

   // phase codes
   localparam logic [1:0] PHASE_RR   = 2'd0;
   localparam logic [1:0] PHASE_SJF  = 2'd1;
   localparam logic [1:0] PHASE_FCFS = 2'd2;
   localparam logic [1:0] PHASE_NONE = 2'd3;

   typedef struct packed {
      logic [7:0] slice_length;
      logic [7:0] preempt_quota;
      logic [3:0] rr_rounds;
      logic [3:0] sjf_rounds;
      logic [3:0] fcfs_rounds;
   } cpts_cfg_type;

   typedef struct packed {
      logic [7:0] slice_left;
      logic [7:0] preempt_left;
      logic [3:0] rr_left;
      logic [3:0] sjf_left;
      logic [3:0] fcfs_left;
   } cpts_state_type;

   typedef struct packed {
      logic       proc_running;
      logic       q0_empty;
      logic       q1_empty;
      logic       q2_empty;
   } cpts_tick_type;

   typedef struct packed {
      logic       yield_now;
      logic [1:0] phase;
   } cpts_result_type;

endpackage

@@ sv/cpts_step.sv @@
module cpts_step (
   input  cpts_pkg::cpts_cfg_type    cfg,
   input  cpts_pkg::cpts_state_type  cur,
   input  cpts_pkg::cpts_tick_type   tick,
   output cpts_pkg::cpts_state_type  nxt,
   output cpts_pkg::cpts_result_type res
);
   import cpts_pkg::*;

   logic handed;
   logic yld;

   // countdowns, phase round accounting and yield decision for one tick
   always_comb begin
      nxt    = cur;
      handed = 1'b0;
      yld    = 1'b0;
      nxt.preempt_left = (cur.preempt_left == 8'd0) ? 8'd0 : cur.preempt_left - 8'd1;
      nxt.slice_left   = (cur.slice_left == 8'd0) ? 8'd0 : cur.slice_left - 8'd1;
      if (tick.proc_running) begin
         if (cur.rr_left != 4'd0) begin
            if (nxt.slice_left == 8'd0) begin
               nxt.slice_left = cfg.slice_length;
               nxt.rr_left    = cur.rr_left - 4'd1;
               if (nxt.rr_left == 4'd0 || tick.q0_empty) begin
                  nxt.sjf_left = cfg.sjf_rounds;
                  handed       = 1'b1;
                  yld          = 1'b1;
               end
            end
            // forced yield in round robin unless a handover just happened
            if (nxt.preempt_left == 8'd0 && !handed) begin
               yld              = 1'b1;
               nxt.preempt_left = cfg.preempt_quota;
            end
         end else if (nxt.slice_left == 8'd0) begin
            nxt.slice_left = cfg.slice_length;
            if (cur.sjf_left != 4'd0) begin
               nxt.sjf_left = cur.sjf_left - 4'd1;
               if (nxt.sjf_left == 4'd0 || tick.q1_empty) begin
                  nxt.fcfs_left = cfg.fcfs_rounds;
                  yld           = 1'b1;
               end
            end else if (cur.fcfs_left != 4'd0) begin
               nxt.fcfs_left = cur.fcfs_left - 4'd1;
               if (nxt.fcfs_left == 4'd0 || tick.q2_empty) begin
                  nxt.rr_left = cfg.rr_rounds;
                  yld         = 1'b1;
               end
            end
         end
      end
   end

   // active phase after the tick
   always_comb begin
      res.yield_now = yld;
      if (nxt.rr_left != 4'd0) begin
         res.phase = PHASE_RR;
      end else if (nxt.sjf_left != 4'd0) begin
         res.phase = PHASE_SJF;
      end else if (nxt.fcfs_left != 4'd0) begin
         res.phase = PHASE_FCFS;
      end else begin
         res.phase = PHASE_NONE;
      end
   end

endmodule

@@ sv/class_phase_time_slice_sequencer.sv @@
// an accepted tick word has its result word registered and shown on rsp in the next cycle
// throughput: one tick per cycle while req_stall is low, the whole update is a single
// pass of counter logic between the state registers and the result register
// req_stall is high only while a result word is held and rsp is stalled
// reset (synchronous, active high) restores register defaults and counters
module class_phase_time_slice_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_proc_running,
   input  logic                                  req_q0_empty,
   input  logic                                  req_q1_empty,
   input  logic                                  req_q2_empty,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_yield_now,
   output logic [1:0]                            rsp_phase,
   input  logic                                  csr_write,
   input  logic [cpts_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cpts_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import cpts_pkg::*;

   cpts_cfg_type    cfg_ff, cfg_in;
   cpts_state_type  state_ff, state_nxt;
   cpts_tick_type   tick;
   cpts_result_type res;
   cpts_result_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_accept;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign tick.proc_running = req_proc_running;
   assign tick.q0_empty     = req_q0_empty;
   assign tick.q1_empty     = req_q1_empty;
   assign tick.q2_empty     = req_q2_empty;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SLICE_LENGTH:  cfg_in.slice_length  = csr_data;
            CSR_PREEMPT_QUOTA: cfg_in.preempt_quota = csr_data;
            CSR_RR_ROUNDS:     cfg_in.rr_rounds     = csr_data[3:0];
            CSR_SJF_ROUNDS:    cfg_in.sjf_rounds    = csr_data[3:0];
            CSR_FCFS_ROUNDS:   cfg_in.fcfs_rounds   = csr_data[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slice_length  <= SLICE_LENGTH_RESET;
         cfg_ff.preempt_quota <= PREEMPT_QUOTA_RESET;
         cfg_ff.rr_rounds     <= RR_ROUNDS_RESET;
         cfg_ff.sjf_rounds    <= SJF_ROUNDS_RESET;
         cfg_ff.fcfs_rounds   <= FCFS_ROUNDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // tick update
   cpts_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .tick (tick),
      .nxt  (state_nxt),
      .res  (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.slice_left   <= SLICE_LENGTH_RESET;
         state_ff.preempt_left <= PREEMPT_QUOTA_RESET;
         state_ff.rr_left      <= RR_ROUNDS_RESET;
         state_ff.sjf_left     <= 4'd0;
         state_ff.fcfs_left    <= 4'd0;
      end else if (req_accept) begin
         state_ff <= state_nxt;
      end
   end

   // result register, held while rsp stalls
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);
   assign rsp_in       = req_accept ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_yield_now = rsp_ff.yield_now;
   assign rsp_phase     = rsp_ff.phase;

endmodule

@@ sv/cpts_checker.sv @@
`include "class_phase_time_slice_sequencer_assert.svh"

module cpts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_proc_running,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_yield_now,
   input logic [1:0] rsp_phase
);

   logic idle_tick;
   logic rsp_held;

   // accepted tick word with no running process, and a result word waiting
   assign idle_tick = req_valid && !req_stall && !req_proc_running;
   assign rsp_held  = rsp_valid && rsp_stall;

   // an idle tick never asks for a yield, and its word shows up next cycle
   `CPTS_ASSERT_NEXT(a_idle_no_yield, clock, reset, idle_tick, rsp_valid && !rsp_yield_now)

   // input is held back only by a stalled result word
   `CPTS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_held)

   // no result word straight after reset
   `CPTS_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

   // a stalled result word holds
   `CPTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable({rsp_yield_now, rsp_phase}))

endmodule

bind class_phase_time_slice_sequencer cpts_checker u_cpts_checker (.*);

@@ tb/sequencer_checker.sv @@
`timescale 1ns / 1ps

module sequencer_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_proc_running,
   input  logic                                  req_q0_empty,
   input  logic                                  req_q1_empty,
   input  logic                                  req_q2_empty,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_yield_now,
   input  logic [1:0]                            rsp_phase,
   input  logic                                  csr_write,
   input  logic [cpts_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cpts_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output int                                    mismatch_count,
   output int                                    outstanding
);
   import cpts_pkg::*;

   cpts_cfg_type    regs;
   cpts_state_type  counters;
   cpts_result_type expected_verdicts [$];
   int              fails = 0;

   // one timer tick: countdowns, round spending and phase handover
   function automatic cpts_result_type schedule_tick(input cpts_tick_type t);
      cpts_result_type r;
      logic            handed;
      r.yield_now = 1'b0;
      handed      = 1'b0;
      if (counters.preempt_left != 8'd0) counters.preempt_left = counters.preempt_left - 8'd1;
      if (counters.slice_left != 8'd0) counters.slice_left = counters.slice_left - 8'd1;

      if (t.proc_running) begin
         if (counters.rr_left != 4'd0) begin
            // round robin: slice expiry may hand over, otherwise preemption yields
            if (counters.slice_left == 8'd0) begin
               counters.slice_left = regs.slice_length;
               counters.rr_left    = counters.rr_left - 4'd1;
               if (counters.rr_left == 4'd0 || t.q0_empty) begin
                  counters.sjf_left = regs.sjf_rounds;
                  handed            = 1'b1;
                  r.yield_now       = 1'b1;
               end
            end
            if (counters.preempt_left == 8'd0 && !handed) begin
               r.yield_now           = 1'b1;
               counters.preempt_left = regs.preempt_quota;
            end
         end else if (counters.slice_left == 8'd0) begin
            counters.slice_left = regs.slice_length;
            if (counters.sjf_left != 4'd0) begin
               counters.sjf_left = counters.sjf_left - 4'd1;
               if (counters.sjf_left == 4'd0 || t.q1_empty) begin
                  counters.fcfs_left = regs.fcfs_rounds;
                  r.yield_now        = 1'b1;
               end
            end else if (counters.fcfs_left != 4'd0) begin
               counters.fcfs_left = counters.fcfs_left - 4'd1;
               if (counters.fcfs_left == 4'd0 || t.q2_empty) begin
                  counters.rr_left = regs.rr_rounds;
                  r.yield_now      = 1'b1;
               end
            end
         end
      end

      // first phase with rounds left wins
      if (counters.rr_left != 4'd0) r.phase = PHASE_RR;
      else if (counters.sjf_left != 4'd0) r.phase = PHASE_SJF;
      else if (counters.fcfs_left != 4'd0) r.phase = PHASE_FCFS;
      else r.phase = PHASE_NONE;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      cpts_tick_type   tick;
      cpts_result_type seen;
      cpts_result_type want;
      if (reset) begin
         regs.slice_length      = SLICE_LENGTH_RESET;
         regs.preempt_quota     = PREEMPT_QUOTA_RESET;
         regs.rr_rounds         = RR_ROUNDS_RESET;
         regs.sjf_rounds        = SJF_ROUNDS_RESET;
         regs.fcfs_rounds       = FCFS_ROUNDS_RESET;
         counters.slice_left    = SLICE_LENGTH_RESET;
         counters.preempt_left  = PREEMPT_QUOTA_RESET;
         counters.rr_left       = RR_ROUNDS_RESET;
         counters.sjf_left      = 4'd0;
         counters.fcfs_left     = 4'd0;
         expected_verdicts.delete();
      end else begin
         // register writes, low bits only for the round counts
         if (csr_write) begin
            case (csr_index)
               CSR_SLICE_LENGTH:  regs.slice_length  = csr_data;
               CSR_PREEMPT_QUOTA: regs.preempt_quota = csr_data;
               CSR_RR_ROUNDS:     regs.rr_rounds     = csr_data[3:0];
               CSR_SJF_ROUNDS:    regs.sjf_rounds    = csr_data[3:0];
               CSR_FCFS_ROUNDS:   regs.fcfs_rounds   = csr_data[3:0];
               default: ;
            endcase
         end

         // result word against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            seen.yield_now = rsp_yield_now;
            seen.phase     = rsp_phase;
            if (expected_verdicts.size() == 0) begin
               fails++;
               $display("%0t unexpected word: expected none, actual yield %b phase %0d",
                        $time, seen.yield_now, seen.phase);
            end else begin
               want = expected_verdicts.pop_front();
               if (seen.yield_now !== want.yield_now || seen.phase !== want.phase) begin
                  fails++;
                  $display("%0t mismatch: expected yield %b phase %0d, actual yield %b phase %0d",
                           $time, want.yield_now, want.phase, seen.yield_now, seen.phase);
               end
            end
         end

         // accepted tick word
         if (req_valid && !req_stall) begin
            tick.proc_running = req_proc_running;
            tick.q0_empty     = req_q0_empty;
            tick.q1_empty     = req_q1_empty;
            tick.q2_empty     = req_q2_empty;
            expected_verdicts.push_back(schedule_tick(tick));
         end
      end
      outstanding    <= expected_verdicts.size();
      mismatch_count <= fails;
   end

endmodule

@@ tb/tb_class_phase_time_slice_sequencer.sv @@
`timescale 1ns / 1ps

module tb_class_phase_time_slice_sequencer;
   import cpts_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;

   logic                       clock;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic                       req_proc_running = 1'b0;
   logic                       req_q0_empty     = 1'b0;
   logic                       req_q1_empty     = 1'b0;
   logic                       req_q2_empty     = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic                       rsp_yield_now;
   logic [1:0]                 rsp_phase;
   logic                       csr_write        = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data         = '0;
   int                         mismatch_count;
   int                         outstanding;

   int                         send_idle_pct    = 0;
   int                         stall_pct        = 0;
   int unsigned                cycles           = 0;

   class_phase_time_slice_sequencer dut (.*);
   sequencer_checker                checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one tick word, then a random idle gap
   task automatic send_tick(input cpts_tick_type t);
      req_valid        <= 1'b1;
      req_proc_running <= t.proc_running;
      req_q0_empty     <= t.q0_empty;
      req_q1_empty     <= t.q1_empty;
      req_q2_empty     <= t.q2_empty;
      do @(posedge clock); while (req_stall);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // hold off until every expected word has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // all five registers, random junk above the 4-bit fields
   task automatic program_regs(input logic [7:0] sl, input logic [7:0] pq,
                               input logic [3:0] rr, input logic [3:0] sjf,
                               input logic [3:0] fcfs);
      csr_write <= 1'b1;
      csr_index <= CSR_SLICE_LENGTH;  csr_data <= sl;                              @(posedge clock);
      csr_index <= CSR_PREEMPT_QUOTA; csr_data <= pq;                              @(posedge clock);
      csr_index <= CSR_RR_ROUNDS;     csr_data <= {4'($urandom_range(15)), rr};    @(posedge clock);
      csr_index <= CSR_SJF_ROUNDS;    csr_data <= {4'($urandom_range(15)), sjf};   @(posedge clock);
      csr_index <= CSR_FCFS_ROUNDS;   csr_data <= {4'($urandom_range(15)), fcfs};  @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      cpts_tick_type t;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      drain();

      // idle ticks at reset values, only the countdowns move
      send_tick(4'b0000); send_tick(4'b0111); send_tick(4'b0000);
      drain();

      // short slices so handovers come quickly
      program_regs(8'd2, 8'd3, 4'd3, 4'd2, 4'd2);
      send_tick(4'b1000); send_tick(4'b1000); send_tick(4'b1000);
      // empty round robin queue while the slice still runs, no handover yet
      send_tick(4'b1100); send_tick(4'b1000); send_tick(4'b1000);
      send_tick(4'b1000); send_tick(4'b1000); send_tick(4'b1010);
      send_tick(4'b1000); send_tick(4'b1010); send_tick(4'b1000);
      send_tick(4'b1001); send_tick(4'b1000); send_tick(4'b1001);
      // idle tick in the middle of a phase
      send_tick(4'b0000); send_tick(4'b1111); send_tick(4'b1111);
      send_tick(4'b1111); send_tick(4'b1000); send_tick(4'b1000);

      // random part over a range of register settings and idle patterns
      for (int s = 0; s < 8; s++) begin
         drain();
         case (s % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         case (s)
            0: program_regs(8'd1, 8'd1, 4'd1, 4'd1, 4'd1);
            1: program_regs(8'd255, 8'd255, 4'd15, 4'd15, 4'd15);
            2: program_regs(8'd2, 8'd3, 4'd2, 4'd3, 4'd2);
            // zero reloads expire again on the next running tick
            3: program_regs(8'd0, 8'd0, 4'd2, 4'd1, 4'd2);
            4: program_regs(8'($urandom_range(6, 1)), 8'($urandom_range(6, 1)),
                            4'($urandom_range(4, 1)), 4'($urandom_range(4, 1)),
                            4'($urandom_range(4, 1)));
            5: program_regs(8'd3, 8'd7, 4'd4, 4'd2, 4'd3);
            6: program_regs(8'($urandom_range(3)), 8'($urandom_range(9)),
                            4'($urandom_range(3, 1)), 4'($urandom_range(3, 1)),
                            4'($urandom_range(3, 1)));
            // zero rounds: once all counters run dry no phase is active again
            default: program_regs(8'd1, 8'd2, 4'd0, 4'd0, 4'd0);
         endcase

         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(9) == 0) begin
               // noise word
               t = 4'($urandom_range(15));
            end else begin
               t.proc_running = ($urandom_range(99) < 85);
               t.q0_empty     = ($urandom_range(99) < 20);
               t.q1_empty     = ($urandom_range(99) < 20);
               t.q2_empty     = ($urandom_range(99) < 20);
            end
            send_tick(t);
            if ($urandom_range(59) == 0) drain();
         end
      end

      send_idle_pct = 0;
      drain();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
